// ===== rtl/q248alu_pkg.sv =====
// Shared types, operation codes and saturation helpers for the Q24.8 fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q248alu_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;

   localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN = 32'h8000_0000;

   // Request fields that travel alongside the divider.
   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic [1:0]  status;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        neg;
      logic        dz;
   } carry_type;

   // 33-bit signed sum to 32 bits; msb of result is the overflow flag.
   function automatic logic [32:0] sat_sum(input logic [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? {1'b1, VAL_MIN} : {1'b1, VAL_MAX};
      end else begin
         r = {1'b0, s[31:0]};
      end
      return r;
   endfunction

   // Magnitude plus sign to 32 bits; msb of result is the overflow flag.
   function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic neg);
      logic [32:0] r;
      if (!neg) begin
         if (m > {32'd0, VAL_MAX}) r = {1'b1, VAL_MAX};
         else r = {1'b0, m[31:0]};
      end else begin
         if (m > {32'd0, VAL_MIN}) r = {1'b1, VAL_MIN};
         else r = {1'b0, 32'(-m[31:0])};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fixed_point_q24_8_alu_top.sv =====
// Top level of the Q24.8 fixed-point ALU: decode, multiply, divide pipeline, result stage.
// Depends on q248alu_pkg and q248alu_div.
//
//   channel   | ports                                      | handshake
//   request   | start, busy, req_operation/operand_a/_b    | start & !busy
//   response  | rsp_valid, rsp_result_value, rsp_is_*,     | rsp_valid, one cycle
//             | rsp_status_code                            |
//
// One request per cycle, through stage 1, stage 2, the divider and the result stage;
// the divider resolves one quotient bit per stage (32 + FRACTION_BITS stages).
// Every operation takes the same path, so responses leave in request order.
// busy is always low: the receiver cannot stall and the pipeline never halts.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_top
   import q248alu_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_operation,
   input  wire logic [31:0] req_operand_a,
   input  wire logic [31:0] req_operand_b,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_value,
   output logic             rsp_is_less,
   output logic             rsp_is_equal,
   output logic             rsp_is_greater,
   output logic [1:0]       rsp_status_code
);

   localparam int QUOT_W = 32 + FRACTION_BITS;

   assign busy = 1'b0;

   // stage 1: simple ops, comparison, product, divider operands
   op_type             op;
   logic signed [31:0] sa, sb;
   logic [32:0]        sat;
   logic [FRACTION_BITS:0] hi;
   logic [31:0]        mag_a, mag_b;
   carry_type          c1_in;

   logic               s1_vld_ff;
   carry_type          s1_carry_ff;
   logic signed [63:0] s1_prod_ff;
   logic [QUOT_W-1:0]  s1_n_ff;
   logic [31:0]        s1_d_ff;

   always_comb begin
      op    = op_type'(req_operation);
      sa    = $signed(req_operand_a);
      sb    = $signed(req_operand_b);
      mag_a = req_operand_a[31] ? 32'(-req_operand_a) : req_operand_a;
      mag_b = req_operand_b[31] ? 32'(-req_operand_b) : req_operand_b;
      hi    = req_operand_a[31 -: FRACTION_BITS+1];
      sat   = '0;
      c1_in = '0;
      c1_in.op  = op;
      c1_in.lt  = (sa < sb);
      c1_in.eq  = (sa == sb);
      c1_in.gt  = (sa > sb);
      c1_in.neg = req_operand_a[31] ^ req_operand_b[31];
      c1_in.dz  = (req_operand_b == 32'd0);
      c1_in.status = ST_OK;
      case (op)
         OP_ADD: sat = sat_sum(33'({sa[31], sa} + {sb[31], sb}));
         OP_SUB: sat = sat_sum(33'({sa[31], sa} - {sb[31], sb}));
         OP_INC: sat = sat_sum(33'({sa[31], sa} + 33'd1));
         OP_DEC: sat = sat_sum(33'({sa[31], sa} - 33'd1));
         OP_MIN: sat = {1'b0, (sa < sb) ? req_operand_a : req_operand_b};
         OP_MAX: sat = {1'b0, (sa > sb) ? req_operand_a : req_operand_b};
         OP_TO_INT: sat = {1'b0, 32'(sa >>> FRACTION_BITS)};
         OP_FROM_INT: begin
            if ((&hi) || !(|hi)) sat = {1'b0, req_operand_a << FRACTION_BITS};
            else sat = {1'b1, req_operand_a[31] ? VAL_MIN : VAL_MAX};
         end
         default: sat = '0;
      endcase
      c1_in.value  = sat[31:0];
      c1_in.status = sat[32] ? ST_OVERFLOW : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
      s1_carry_ff <= c1_in;
      s1_prod_ff  <= 64'(sa) * 64'(sb);
      s1_n_ff     <= {mag_a, {FRACTION_BITS{1'b0}}};
      s1_d_ff     <= mag_b;
   end

   // stage 2: multiply rounding and saturation
   logic [63:0] pmag;
   logic [63:0] pround;
   logic [32:0] msat;
   carry_type   c2_in;

   logic              s2_vld_ff;
   carry_type         s2_carry_ff;
   logic [QUOT_W-1:0] s2_n_ff;
   logic [31:0]       s2_d_ff;

   always_comb begin
      pmag   = s1_prod_ff[63] ? 64'(-s1_prod_ff) : 64'(s1_prod_ff);
      pround = (pmag + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      msat   = sat_mag(pround, s1_prod_ff[63]);
      c2_in  = s1_carry_ff;
      if (s1_carry_ff.op == OP_MUL) begin
         c2_in.value  = msat[31:0];
         c2_in.status = msat[32] ? ST_OVERFLOW : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_carry_ff <= c2_in;
      s2_n_ff     <= s1_n_ff;
      s2_d_ff     <= s1_d_ff;
   end

   // divide stages
   logic              dv_valid;
   logic [QUOT_W-1:0] dv_quot;
   logic [31:0]       dv_rem;
   logic [31:0]       dv_d;
   carry_type         dv_carry;

   q248alu_div #(
      .QUOT_W (QUOT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_n      (s2_n_ff),
      .in_d      (s2_d_ff),
      .in_carry  (s2_carry_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_rem   (dv_rem),
      .out_d     (dv_d),
      .out_carry (dv_carry)
   );

   // result stage: round quotient half away from zero, saturate, select
   logic [QUOT_W:0] qr;
   logic [32:0]     dsat;
   logic [31:0]     value_in;
   logic [1:0]      status_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_lt_ff, rsp_eq_ff, rsp_gt_ff;
   logic [1:0]  rsp_status_ff;

   always_comb begin
      qr = {1'b0, dv_quot} + (QUOT_W+1)'({dv_rem, 1'b0} >= {1'b0, dv_d});
      dsat      = sat_mag(64'(qr), dv_carry.neg);
      value_in  = dv_carry.value;
      status_in = dv_carry.status;
      if (dv_carry.op == OP_DIV) begin
         if (dv_carry.dz) begin
            value_in  = '0;
            status_in = ST_DIV_ZERO;
         end else begin
            value_in  = dsat[31:0];
            status_in = dsat[32] ? ST_OVERFLOW : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_value_ff  <= value_in;
      rsp_lt_ff     <= dv_carry.lt;
      rsp_eq_ff     <= dv_carry.eq;
      rsp_gt_ff     <= dv_carry.gt;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_is_less      = rsp_lt_ff;
   assign rsp_is_equal     = rsp_eq_ff;
   assign rsp_is_greater   = rsp_gt_ff;
   assign rsp_status_code  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== rtl/q248alu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on q248alu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q248alu_div
   import q248alu_pkg::*;
#(
   parameter int QUOT_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [QUOT_W-1:0] in_n,
   input  wire logic [31:0]       in_d,
   input  wire carry_type         in_carry,
   output logic                   out_valid,
   output logic [QUOT_W-1:0]      out_quot,
   output logic [31:0]            out_rem,
   output logic [31:0]            out_d,
   output carry_type              out_carry
);

   logic              vld_ff   [0:QUOT_W-1];
   logic [QUOT_W-1:0] n_ff     [0:QUOT_W-1];
   logic [QUOT_W-1:0] q_ff     [0:QUOT_W-1];
   logic [31:0]       rem_ff   [0:QUOT_W-1];
   logic [31:0]       d_ff     [0:QUOT_W-1];
   carry_type         carry_ff [0:QUOT_W-1];

   genvar k;
   generate
      for (k = 0; k < QUOT_W; k++) begin : g_stage
         logic              vld_p;
         logic [QUOT_W-1:0] n_p;
         logic [QUOT_W-1:0] q_p;
         logic [31:0]       rem_p;
         logic [31:0]       d_p;
         carry_type         carry_p;
         logic [32:0]       trial;
         logic              ge;
         logic [31:0]       rem_in;
         logic [QUOT_W-1:0] q_in;

         if (k == 0) begin : g_first
            assign vld_p   = in_valid;
            assign n_p     = in_n;
            assign q_p     = '0;
            assign rem_p   = '0;
            assign d_p     = in_d;
            assign carry_p = in_carry;
         end else begin : g_next
            assign vld_p   = vld_ff[k-1];
            assign n_p     = n_ff[k-1];
            assign q_p     = q_ff[k-1];
            assign rem_p   = rem_ff[k-1];
            assign d_p     = d_ff[k-1];
            assign carry_p = carry_ff[k-1];
         end

         always_comb begin
            trial  = {rem_p, n_p[QUOT_W-1-k]};
            ge     = (trial >= {1'b0, d_p});
            rem_in = ge ? 32'(trial - {1'b0, d_p}) : trial[31:0];
            q_in   = {q_p[QUOT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_p;
            end
            n_ff[k]     <= n_p;
            q_ff[k]     <= q_in;
            rem_ff[k]   <= rem_in;
            d_ff[k]     <= d_p;
            carry_ff[k] <= carry_p;
         end
      end
   endgenerate

   assign out_valid = vld_ff[QUOT_W-1];
   assign out_quot  = q_ff[QUOT_W-1];
   assign out_rem   = rem_ff[QUOT_W-1];
   assign out_d     = d_ff[QUOT_W-1];
   assign out_carry = carry_ff[QUOT_W-1];

endmodule
`default_nettype wire
